// ===== rtl/core/tdfm_pkg.sv =====
// Shared constants, types and helpers for the tile dedup flip matcher.
package tdfm_pkg;

  localparam int TILE_SLOTS = 1024;
  localparam int ROWS       = 8;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int SLOT_W     = $clog2(TILE_SLOTS);
  localparam int CNT_W      = $clog2(TILE_SLOTS + 1);
  localparam int ADDR_W     = SLOT_W + ROW_W;
  localparam int PIX_W      = 64;
  localparam int IDX_W      = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIT_DEPTH = 2'd0,
    CFG_AFFINE    = 2'd1,
    CFG_PALETTE   = 2'd2,
    CFG_MAX_TILES = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } ctrl_state_t;

  typedef struct packed {
    logic load_row;
    logic start_scan;
    logic scan;
    logic write;
    logic fin_hit;
    logic fin_full;
    logic fin_new;
  } dp_cmd_t;

  typedef struct packed {
    logic last_row;
    logic out_busy;
    logic count_zero;
    logic hit;
    logic last_slot;
    logic full;
    logic wr_last;
  } dp_status_t;

  // Mirror the pixel order of one row, 4 or 8 bits per pixel.
  function automatic logic [PIX_W-1:0] rev_pixels(input logic [PIX_W-1:0] row,
                                                   input logic depth8);
    logic [PIX_W-1:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (depth8) begin
        r[8*(7-i) +: 8] = row[8*i +: 8];
      end else begin
        r[4*(7-i) +: 4] = row[4*i +: 4];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tdfm_ifs.sv =====
// Channel interfaces: input rows, results and configuration writes.
interface tdfm_in_if;
  import tdfm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] row_pixels;
  logic             image_start;
  modport source (output valid, row_pixels, image_start, input ready);
  modport sink (input valid, row_pixels, image_start, output ready);
endinterface

interface tdfm_out_if;
  import tdfm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] tile_index;
  logic             horizontal_flip;
  logic             vertical_flip;
  logic [3:0]       palette_number;
  logic             new_tile;
  logic             overflow_error;
  modport source (output valid, tile_index, horizontal_flip, vertical_flip,
                  palette_number, new_tile, overflow_error, input ready);
  modport sink (input valid, tile_index, horizontal_flip, vertical_flip,
                palette_number, new_tile, overflow_error, output ready);
endinterface

interface tdfm_cfg_if;
  import tdfm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tdfm_ram.sv =====
// Generic single-port RAM with registered read.
module tdfm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/tdfm_ctrl.sv =====
// Controller: sequences row loading, tileset search and tile append.
module tdfm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_image_start,
  output logic                in_ready,
  input  tdfm_pkg::dp_status_t st,
  output tdfm_pkg::dp_cmd_t    cmd
);
  import tdfm_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // eighth row must wait for a free output register
        in_ready = !(st.last_row && st.out_busy);
        if (in_valid && in_ready) begin
          cmd.load_row = 1'b1;
          if (!in_image_start && st.last_row) begin
            cmd.start_scan = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          cmd.fin_hit = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (st.count_zero || st.last_slot) begin
          if (st.full) begin
            cmd.fin_full = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        cmd.write = 1'b1;
        if (st.wr_last) begin
          cmd.fin_new = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

// ===== rtl/core/tdfm_dp.sv =====
// Datapath: config registers, row rings, tile store, comparators, result register.
module tdfm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [tdfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdfm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tdfm_pkg::PIX_W-1:0]      in_row_pixels,
  input  logic                            in_image_start,
  input  tdfm_pkg::dp_cmd_t               cmd,
  output tdfm_pkg::dp_status_t            st,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [tdfm_pkg::IDX_W-1:0]      out_tile_index,
  output logic                            out_horizontal_flip,
  output logic                            out_vertical_flip,
  output logic [3:0]                      out_palette_number,
  output logic                            out_new_tile,
  output logic                            out_overflow_error
);
  import tdfm_pkg::*;

  logic                  bit_depth_r, affine_r;
  logic [3:0]            palette_r;
  logic [CFG_DATA_W-1:0] max_tiles_r;
  logic [CNT_W-1:0]      count_r;
  logic [ROW_W-1:0]      pos_r, wr_row_r;
  logic [ADDR_W-1:0]     iss_addr_r, cmp_addr_r, ram_addr;
  logic                  cmp_vld_r, cmp_en;
  logic [3:0]            match_r, match_cur, eq, hits;
  logic [PIX_W-1:0]      fwd_r [ROWS];
  logic [PIX_W-1:0]      bwd_r [ROWS];
  logic [PIX_W-1:0]      mask, srow, row_a, row_b;
  logic [SLOT_W-1:0]     cmp_slot;
  logic [ROW_W-1:0]      cmp_row;
  logic [31:0]           limit, idx_mask, idx_full;
  logic                  out_valid_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  hf_r, vf_r, new_r, ovf_r;
  logic [3:0]            pal_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_depth_r <= 1'b0;
      affine_r    <= 1'b0;
      palette_r   <= '0;
      max_tiles_r <= CFG_DATA_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_BIT_DEPTH: bit_depth_r <= cfg_data[0];
        CFG_AFFINE:    affine_r    <= cfg_data[0];
        CFG_PALETTE:   palette_r   <= cfg_data[3:0];
        CFG_MAX_TILES: max_tiles_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // current tile: fwd ring taps row r at [0], bwd ring taps row 7-r at [ROWS-1]
  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      for (int i = 0; i < ROWS - 1; i++) begin
        fwd_r[i] <= fwd_r[i+1];
        bwd_r[i] <= bwd_r[i+1];
      end
      fwd_r[ROWS-1] <= in_row_pixels;
      bwd_r[ROWS-1] <= in_row_pixels;
    end else if (cmp_en) begin
      for (int i = 0; i < ROWS - 1; i++) begin
        fwd_r[i]   <= fwd_r[i+1];
        bwd_r[i+1] <= bwd_r[i];
      end
      fwd_r[ROWS-1] <= fwd_r[0];
      bwd_r[0]      <= bwd_r[ROWS-1];
    end else if (cmd.write) begin
      for (int i = 0; i < ROWS - 1; i++) begin
        fwd_r[i] <= fwd_r[i+1];
      end
      fwd_r[ROWS-1] <= fwd_r[0];
    end
  end

  assign ram_addr = cmd.write ? {count_r[SLOT_W-1:0], wr_row_r} : iss_addr_r;

  tdfm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (TILE_SLOTS * ROWS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write),
    .addr  (ram_addr),
    .wdata (fwd_r[0]),
    .rdata (srow)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pos_r      <= '0;
      wr_row_r   <= '0;
      iss_addr_r <= '0;
      cmp_vld_r  <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.scan;
      if (cmd.start_scan) begin
        iss_addr_r <= '0;
      end else if (cmd.scan) begin
        iss_addr_r <= iss_addr_r + 1'b1;
      end
      if (cmd.write) begin
        wr_row_r <= wr_row_r + 1'b1;
      end
      if (cmd.load_row) begin
        if (in_image_start) begin
          count_r <= '0;
          pos_r   <= ROW_W'(1);
        end else begin
          pos_r <= pos_r + 1'b1;
        end
      end else if (cmd.fin_new) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_addr_r <= iss_addr_r;
    if (cmp_en) begin
      match_r <= match_cur;
    end
  end

  assign cmp_en   = cmd.scan && cmp_vld_r;
  assign cmp_slot = cmp_addr_r[ADDR_W-1:ROW_W];
  assign cmp_row  = cmp_addr_r[ROW_W-1:0];
  assign mask     = bit_depth_r ? '1 : PIX_W'(32'hFFFF_FFFF);
  assign row_a    = fwd_r[0];
  assign row_b    = bwd_r[ROWS-1];

  // bit k: k[0] vertical flip, k[1] horizontal flip
  assign eq[0] = (srow & mask) == (row_a & mask);
  assign eq[1] = (srow & mask) == (row_b & mask);
  assign eq[2] = (srow & mask) == (rev_pixels(row_a, bit_depth_r) & mask);
  assign eq[3] = (srow & mask) == (rev_pixels(row_b, bit_depth_r) & mask);

  assign match_cur = ((cmp_row == '0) ? 4'hF : match_r) & eq;
  assign hits      = match_cur & (affine_r ? 4'b0001 : 4'b1111);

  assign limit    = (32'(max_tiles_r) < 32'(TILE_SLOTS)) ? 32'(max_tiles_r)
                                                         : 32'(TILE_SLOTS);
  assign idx_mask = affine_r ? 32'h0FF : 32'h3FF;
  assign idx_full = 32'(count_r) & idx_mask;

  always_comb begin
    st            = '0;
    st.last_row   = (pos_r == ROW_W'(ROWS - 1));
    st.out_busy   = out_valid_r;
    st.count_zero = (count_r == '0);
    st.hit        = cmp_en && (cmp_row == ROW_W'(ROWS - 1)) && (hits != '0);
    st.last_slot  = cmp_en && (cmp_row == ROW_W'(ROWS - 1))
                    && ((32'(cmp_slot) + 32'd1) == 32'(count_r));
    st.full       = (32'(count_r) >= limit);
    st.wr_last    = cmd.write && (wr_row_r == ROW_W'(ROWS - 1));
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin_hit || cmd.fin_full || cmd.fin_new) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_hit || cmd.fin_full || cmd.fin_new) begin
      pal_r <= affine_r ? 4'd0 : palette_r;
      new_r <= cmd.fin_new;
      ovf_r <= cmd.fin_full;
      if (cmd.fin_hit) begin
        idx_r <= IDX_W'(32'(cmp_slot) & idx_mask);
        // lowest hit wins: exact, vertical, horizontal, both
        if (hits[0]) begin
          hf_r <= 1'b0;
          vf_r <= 1'b0;
        end else if (hits[1]) begin
          hf_r <= 1'b0;
          vf_r <= 1'b1;
        end else if (hits[2]) begin
          hf_r <= 1'b1;
          vf_r <= 1'b0;
        end else begin
          hf_r <= 1'b1;
          vf_r <= 1'b1;
        end
      end else begin
        idx_r <= idx_full[IDX_W-1:0];
        hf_r  <= 1'b0;
        vf_r  <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tile_index      = idx_r;
  assign out_horizontal_flip = hf_r;
  assign out_vertical_flip   = vf_r;
  assign out_palette_number  = pal_r;
  assign out_new_tile        = new_r;
  assign out_overflow_error  = ovf_r;
endmodule

// ===== rtl/core/tile_dedup_flip_matcher.sv =====
// Top level: 8x8 tile deduplication with flip matching.
// Rows 1 to 7 of a tile only load the row rings; the eighth row starts a search over the
// single-port store, one stored row per cycle, which stops early on a hit; with no hit
// and room left, the new tile is then appended to the store.
// Results sit in an output register; the next tile's first seven rows flow while it waits.
// Reset clears control state, config and the tile count; the tile store is not cleared.
module tile_dedup_flip_matcher (
  input logic        clk,
  input logic        rst_n,
  tdfm_in_if.sink    in_ch,
  tdfm_out_if.source out_ch,
  tdfm_cfg_if.sink   cfg_ch
);
  import tdfm_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  assign cfg_ch.ready = 1'b1;

  tdfm_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_image_start (in_ch.image_start),
    .in_ready       (in_ch.ready),
    .st             (st),
    .cmd            (cmd)
  );

  tdfm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_ch.valid),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .in_row_pixels       (in_ch.row_pixels),
    .in_image_start      (in_ch.image_start),
    .cmd                 (cmd),
    .st                  (st),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_tile_index      (out_ch.tile_index),
    .out_horizontal_flip (out_ch.horizontal_flip),
    .out_vertical_flip   (out_ch.vertical_flip),
    .out_palette_number  (out_ch.palette_number),
    .out_new_tile        (out_ch.new_tile),
    .out_overflow_error  (out_ch.overflow_error)
  );

  a_no_input_during_search: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan || cmd.write) |-> !in_ch.ready)
    else $error("input ready while search or append in progress");

  a_new_xor_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.new_tile && out_ch.overflow_error))
    else $error("new tile and overflow reported together");

  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin_hit |=> (out_ch.valid && !out_ch.new_tile && !out_ch.overflow_error))
    else $error("match did not produce a plain result");
endmodule
